// File: rtl/swst_pkg.sv
// Types and constants shared by the sliding window sender table.
package swst_pkg;

  localparam int WINDOW_DEPTH = 4;
  localparam int SEQ_W        = 8;
  localparam int SLOT_W       = $clog2(WINDOW_DEPTH);
  localparam int CNT_W        = $clog2(WINDOW_DEPTH + 1);
  localparam int POS_W        = 2;
  localparam int OCC_W        = 3;

  typedef enum logic [1:0] {
    KIND_ADD     = 2'd0,
    KIND_RELEASE = 2'd1,
    KIND_LOCATE  = 2'd2,
    KIND_TAKE    = 2'd3
  } kind_e;

  typedef enum logic [1:0] {
    STATUS_OK        = 2'd0,
    STATUS_NOT_FOUND = 2'd1,
    STATUS_FULL      = 2'd2
  } status_e;

  typedef struct packed {
    kind_e            kind;
    logic [SEQ_W-1:0] seq_arg;
  } swst_in_t;

  typedef struct packed {
    status_e          status;
    logic [POS_W-1:0] position;
    logic [SEQ_W-1:0] seq_out;
    logic             is_full;
    logic [OCC_W-1:0] occupancy;
  } swst_out_t;

  // Shared by every cell of the ring.
  typedef struct packed {
    logic             rotate;
    logic [SEQ_W-1:0] key;
  } swst_bcast_t;

endpackage

// File: rtl/swst_cell.sv
// One slot of the window ring: holds a sequence number and compares it.
module swst_cell import swst_pkg::*; (
  input  logic             clk_i,
  input  swst_bcast_t      bcast_i,
  input  logic             wr_en_i,
  input  logic             live_i,
  input  logic [SEQ_W-1:0] nbr_seq_i,
  input  logic             hit_i,
  output logic [SEQ_W-1:0] seq_o,
  output logic             hit_o,
  output logic             first_o
);

  logic [SEQ_W-1:0] seq_q;
  logic             match;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      seq_q <= bcast_i.key;
    end else if (bcast_i.rotate) begin
      seq_q <= nbr_seq_i;
    end
  end

  assign match   = live_i && (seq_q == bcast_i.key);
  assign hit_o   = hit_i | match;
  assign first_o = match & ~hit_i;
  assign seq_o   = seq_q;

endmodule

// File: rtl/sliding_window_sender_table_core.sv
// Top level of the sliding window sender table.
//
// The window is a ring of WINDOW_DEPTH cells kept in age order: cell 0 holds
// the entry at the head slot whenever the ring is not rotating. Each result is
// registered, and a new item is taken every cycle while the result register
// can drain and no rotation is under way. A release that frees m entries
// rotates the ring by one cell per cycle, and the input is stalled until the
// rotation is done; the release result is registered without waiting for it.
// WINDOW_DEPTH must be a power of two. No clearing pass after reset.
module sliding_window_sender_table_core import swst_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_stall_o,
  input  swst_in_t  in_item_i,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output swst_out_t out_item_o
);

  logic [SLOT_W-1:0] head_q, head_d;
  logic [CNT_W-1:0]  fill_q, fill_d;
  logic [SEQ_W-1:0]  next_seq_q, next_seq_d;
  logic [CNT_W-1:0]  rot_left_q, rot_left_d;
  logic              out_valid_q, out_valid_d;
  swst_out_t         out_item_q, res;

  logic                         busy, accept_in;
  swst_bcast_t                  bcast;
  logic [WINDOW_DEPTH-1:0]      wr_en, live, first;
  logic [WINDOW_DEPTH:0]        hit_chain;
  logic [SEQ_W-1:0]             cell_seq [WINDOW_DEPTH];
  logic [CNT_W-1:0]             rel_cnt;
  logic [CNT_W:0]               head_sum;
  logic [SEQ_W-1:0]             offset;
  logic [SLOT_W-1:0]            pos_slot;

  assign busy       = (rot_left_q != '0);
  assign in_stall_o = busy | (out_valid_q & out_stall_i);
  assign accept_in  = in_valid_i & ~in_stall_o;

  assign bcast.rotate = busy;
  assign bcast.key    = in_item_i.seq_arg;
  assign hit_chain[0] = 1'b0;

  for (genvar k = 0; k < WINDOW_DEPTH; k++) begin : g_cell
    assign live[k]  = fill_q > CNT_W'(k);
    assign wr_en[k] = accept_in && (in_item_i.kind == KIND_ADD) && (fill_q == CNT_W'(k));

    swst_cell u_cell (
      .clk_i     (clk_i),
      .bcast_i   (bcast),
      .wr_en_i   (wr_en[k]),
      .live_i    (live[k]),
      .nbr_seq_i (cell_seq[(k + 1) % WINDOW_DEPTH]),
      .hit_i     (hit_chain[k]),
      .seq_o     (cell_seq[k]),
      .hit_o     (hit_chain[k+1]),
      .first_o   (first[k])
    );
  end

  always_comb begin
    rel_cnt = '0;
    for (int k = 0; k < WINDOW_DEPTH; k++) begin
      if (first[k]) begin
        rel_cnt = CNT_W'(k + 1);
      end
    end
  end

  assign head_sum = (CNT_W+1)'(head_q) + (CNT_W+1)'(rel_cnt);
  assign offset   = in_item_i.seq_arg - cell_seq[0];
  assign pos_slot = head_q + offset[SLOT_W-1:0];

  always_comb begin
    head_d         = head_q;
    fill_d         = fill_q;
    next_seq_d     = next_seq_q;
    rot_left_d     = busy ? rot_left_q - CNT_W'(1) : rot_left_q;
    res.status     = STATUS_OK;
    res.position   = '0;
    res.seq_out    = '0;

    if (accept_in) begin
      unique case (in_item_i.kind)
        KIND_ADD: begin
          if (fill_q == CNT_W'(WINDOW_DEPTH)) begin
            res.status = STATUS_FULL;
          end else begin
            fill_d = fill_q + CNT_W'(1);
          end
        end
        KIND_RELEASE: begin
          if (hit_chain[WINDOW_DEPTH]) begin
            fill_d     = fill_q - rel_cnt;
            rot_left_d = rel_cnt;
            if (head_sum >= (CNT_W+1)'(WINDOW_DEPTH)) begin
              head_d = SLOT_W'(head_sum - (CNT_W+1)'(WINDOW_DEPTH));
            end else begin
              head_d = SLOT_W'(head_sum);
            end
          end else begin
            res.status = STATUS_NOT_FOUND;
          end
        end
        KIND_LOCATE: begin
          res.position = POS_W'(pos_slot);
        end
        KIND_TAKE: begin
          res.seq_out = next_seq_q;
          next_seq_d  = next_seq_q + SEQ_W'(1);
        end
        default: begin
          res.status = STATUS_OK;
        end
      endcase
    end

    res.is_full   = (fill_d == CNT_W'(WINDOW_DEPTH));
    res.occupancy = OCC_W'(fill_d);
  end

  always_comb begin
    if (accept_in) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q      <= '0;
      fill_q      <= '0;
      next_seq_q  <= '0;
      rot_left_q  <= '0;
      out_valid_q <= 1'b0;
    end else begin
      head_q      <= head_d;
      fill_q      <= fill_d;
      next_seq_q  <= next_seq_d;
      rot_left_q  <= rot_left_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept_in) begin
      out_item_q <= res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_item_q;

endmodule

// File: tb/tb_sliding_window_sender_table_core.sv
// Self-checking testbench for the sliding window sender table core.
module tb_sliding_window_sender_table_core;
  import swst_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int RAND_ITEMS  = 1280;
  localparam int CYCLE_LIMIT = 200000;
  localparam int HOLD_CYCLES = 40;

  typedef struct {
    swst_in_t  item;
    bit        typed;
    swst_out_t want;
  } step_row_t;

  logic      clk_i = 1'b0;
  logic      rst_ni;
  logic      in_valid_i;
  logic      in_stall_o;
  swst_in_t  in_item_i;
  logic      out_valid_o;
  logic      out_stall_i;
  swst_out_t out_item_o;

  // Window shadow state
  logic [SEQ_W-1:0]        win_seq [WINDOW_DEPTH];
  logic [WINDOW_DEPTH-1:0] win_written = '0;
  int                      win_head    = 0;
  int                      win_fill    = 0;
  logic [SEQ_W-1:0]        seq_next    = '0;

  swst_out_t expected_q[$];
  step_row_t directed_steps[$];

  int  idle_pct       = 20;
  bit  hold_req       = 1'b0;
  int  hold_cycles;
  int  cycle_count    = 0;
  int  mismatch_count = 0;
  int  results_seen   = 0;
  int  kind_count[4]  = '{0, 0, 0, 0};
  int  full_rejects   = 0;
  int  release_misses = 0;

  sliding_window_sender_table_core uut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_item_i  (in_item_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_item_o (out_item_o)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles, %0d results pending", cycle_count,
               expected_q.size());
      $display("CHECKS FAILED");
      $finish;
    end
  end

  function automatic swst_out_t window_step(swst_in_t it);
    swst_out_t        r;
    int               hit;
    logic [SEQ_W-1:0] offs;
    r   = '0;
    hit = -1;
    case (it.kind)
      KIND_ADD: begin
        if (win_fill >= WINDOW_DEPTH) begin
          r.status = STATUS_FULL;
        end else begin
          win_seq[(win_head + win_fill) % WINDOW_DEPTH] = it.seq_arg;
          win_written[(win_head + win_fill) % WINDOW_DEPTH] = 1'b1;
          win_fill++;
        end
      end
      KIND_RELEASE: begin
        for (int i = win_fill - 1; i >= 0; i--)
          if (win_seq[(win_head + i) % WINDOW_DEPTH] == it.seq_arg) hit = i;
        if (hit < 0) begin
          r.status = STATUS_NOT_FOUND;
        end else begin
          win_head = (win_head + hit + 1) % WINDOW_DEPTH;
          win_fill -= hit + 1;
        end
      end
      KIND_LOCATE: begin
        offs = it.seq_arg - win_seq[win_head];
        r.position = POS_W'((win_head + int'(offs)) % WINDOW_DEPTH);
      end
      default: begin
        r.seq_out = seq_next;
        seq_next  = seq_next + 8'd1;
      end
    endcase
    r.is_full   = (win_fill >= WINDOW_DEPTH);
    r.occupancy = OCC_W'(win_fill);
    return r;
  endfunction

  // Mostly go-back-N traffic: add the number just taken, ack numbers in flight.
  function automatic swst_in_t pick_item();
    swst_in_t it;
    int       roll;
    roll = $urandom_range(0, 99);
    it.seq_arg = ($urandom_range(0, 4) == 0) ? 8'($urandom_range(0, 7)) : 8'($urandom);
    if (roll < 30) begin
      it.kind = KIND_ADD;
      if ($urandom_range(0, 1) == 1) it.seq_arg = seq_next - 8'd1;
    end else if (roll < 55) begin
      it.kind = KIND_RELEASE;
      if (win_fill > 0 && $urandom_range(0, 3) != 0)
        it.seq_arg = win_seq[(win_head + $urandom_range(0, win_fill - 1)) % WINDOW_DEPTH];
    end else if (roll < 70 && win_written[win_head]) begin
      it.kind = KIND_LOCATE;
      if (win_fill > 0 && $urandom_range(0, 1) == 1)
        it.seq_arg = win_seq[(win_head + $urandom_range(0, win_fill - 1)) % WINDOW_DEPTH];
    end else begin
      it.kind = KIND_TAKE;
    end
    return it;
  endfunction

  task automatic plan_step(kind_e k, logic [SEQ_W-1:0] arg, bit typed = 1'b0,
                           status_e st = STATUS_OK, logic [POS_W-1:0] pos = '0,
                           bit full = 1'b0, logic [OCC_W-1:0] occ = '0);
    step_row_t r;
    r.item.kind       = k;
    r.item.seq_arg    = arg;
    r.typed           = typed;
    r.want            = '0;
    r.want.status     = st;
    r.want.position   = pos;
    r.want.is_full    = full;
    r.want.occupancy  = occ;
    directed_steps.push_back(r);
  endtask

  task automatic send_item(swst_in_t it, bit typed, swst_out_t want);
    swst_out_t pred;
    in_item_i  <= it;
    in_valid_i <= 1'b1;
    do @(posedge clk_i); while (in_stall_o);
    pred = window_step(it);
    expected_q.push_back(typed ? want : pred);
    kind_count[it.kind]++;
    if (pred.status == STATUS_FULL) full_rejects++;
    if (it.kind == KIND_RELEASE && pred.status == STATUS_NOT_FOUND) release_misses++;
    if ($urandom_range(0, 99) < idle_pct) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk_i);
    end
  endtask

  // Result sink with random stall bursts and one long hold-off.
  initial begin
    out_stall_i = 1'b0;
    wait (rst_ni === 1'b1);
    forever begin
      @(posedge clk_i);
      if (hold_req) begin
        hold_req = 1'b0;
        out_stall_i <= 1'b1;
        for (hold_cycles = 0; hold_cycles < HOLD_CYCLES; hold_cycles++) @(posedge clk_i);
        out_stall_i <= 1'b0;
      end else if ($urandom_range(0, 99) < idle_pct) begin
        out_stall_i <= 1'b1;
        repeat ($urandom_range(1, 3)) @(posedge clk_i);
        out_stall_i <= 1'b0;
      end
    end
  end

  always @(posedge clk_i) begin
    swst_out_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      results_seen++;
      if (expected_q.size() == 0) begin
        if (mismatch_count < 10)
          $display("Unexpected result: status %0d pos %0d seq %0d full %0b occ %0d",
                   out_item_o.status, out_item_o.position, out_item_o.seq_out,
                   out_item_o.is_full, out_item_o.occupancy);
        mismatch_count++;
      end else begin
        want = expected_q.pop_front();
        if (out_item_o.status !== want.status || out_item_o.position !== want.position ||
            out_item_o.seq_out !== want.seq_out || out_item_o.is_full !== want.is_full ||
            out_item_o.occupancy !== want.occupancy) begin
          if (mismatch_count < 10) begin
            $display("Mismatch on result %0d: exp status %0d pos %0d seq %0d full %0b occ %0d",
                     results_seen, want.status, want.position, want.seq_out,
                     want.is_full, want.occupancy);
            $display("  got status %0d pos %0d seq %0d full %0b occ %0d",
                     out_item_o.status, out_item_o.position, out_item_o.seq_out,
                     out_item_o.is_full, out_item_o.occupancy);
          end
          mismatch_count++;
        end
      end
    end
  end

  initial begin
    rst_ni     = 1'b0;
    in_valid_i = 1'b0;
    in_item_i  = '0;

    plan_step(KIND_RELEASE, 8'd0,   1'b1, STATUS_NOT_FOUND, 2'd0, 1'b0, 3'd0);
    plan_step(KIND_TAKE,    8'd0,   1'b1, STATUS_OK,        2'd0, 1'b0, 3'd0);
    plan_step(KIND_TAKE,    8'd255);
    plan_step(KIND_ADD,     8'd0,   1'b1, STATUS_OK,        2'd0, 1'b0, 3'd1);
    plan_step(KIND_ADD,     8'd255);
    plan_step(KIND_ADD,     8'd255);
    plan_step(KIND_ADD,     8'd128, 1'b1, STATUS_OK,        2'd0, 1'b1, 3'd4);
    plan_step(KIND_ADD,     8'd1,   1'b1, STATUS_FULL,      2'd0, 1'b1, 3'd4);
    plan_step(KIND_LOCATE,  8'd0,   1'b1, STATUS_OK,        2'd0, 1'b1, 3'd4);
    plan_step(KIND_LOCATE,  8'd255, 1'b1, STATUS_OK,        2'd3, 1'b1, 3'd4);
    plan_step(KIND_LOCATE,  8'd130);
    plan_step(KIND_RELEASE, 8'd7,   1'b1, STATUS_NOT_FOUND, 2'd0, 1'b1, 3'd4);
    plan_step(KIND_RELEASE, 8'd255);
    plan_step(KIND_LOCATE,  8'd0);
    plan_step(KIND_ADD,     8'd85);
    plan_step(KIND_ADD,     8'd170);
    plan_step(KIND_TAKE,    8'd0);
    plan_step(KIND_RELEASE, 8'd170);
    plan_step(KIND_LOCATE,  8'd3);
    plan_step(KIND_RELEASE, 8'd255, 1'b1, STATUS_NOT_FOUND, 2'd0, 1'b0, 3'd0);
    plan_step(KIND_ADD,     8'd0);
    plan_step(KIND_RELEASE, 8'd0);
    plan_step(KIND_TAKE,    8'd0);

    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;

    foreach (directed_steps[i])
      send_item(directed_steps[i].item, directed_steps[i].typed, directed_steps[i].want);

    for (int n = 0; n < RAND_ITEMS; n++) begin
      if (n % 100 == 0) begin
        case ($urandom_range(0, 2))
          0:       idle_pct = 0;
          1:       idle_pct = 15;
          default: idle_pct = 40;
        endcase
        if (n == 500 || n >= RAND_ITEMS - 200) idle_pct = 0;
      end
      if (n == 500) hold_req = 1'b1;
      send_item(pick_item(), 1'b0, '0);
    end
    in_valid_i <= 1'b0;

    while (expected_q.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
    if (expected_q.size() != 0) begin
      $display("%0d results never arrived", expected_q.size());
      mismatch_count++;
    end

    $display("Sent %0d items (add %0d, release %0d, locate %0d, take %0d), checked %0d results.",
             directed_steps.size() + RAND_ITEMS, kind_count[KIND_ADD],
             kind_count[KIND_RELEASE], kind_count[KIND_LOCATE], kind_count[KIND_TAKE],
             results_seen);
    $display("Saw %0d adds to a full window, %0d missed releases, %0d number wraps, %0d errors.",
             full_rejects, release_misses, kind_count[KIND_TAKE] / 256, mismatch_count);
    if (mismatch_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
